// File: sv/cursor_sequence_store_assert.svh
// Assertion macros used by the cursor sequence store sequencer (css_ctrl).
`ifndef CURSOR_SEQUENCE_STORE_ASSERT_SVH
`define CURSOR_SEQUENCE_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cursor_sequence_store: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cursor_sequence_store: next-cycle check failed");

`endif

// File: sv/css_pkg.sv
// Package with the transaction types, operation codes and status codes of the store.
`timescale 1ns / 1ps
`default_nettype none
package css_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [2:0] OP_QUERY  = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_ADV    = 3'd2;
	localparam logic [2:0] OP_INSERT = 3'd3;
	localparam logic [2:0] OP_ATTACH = 3'd4;
	localparam logic [2:0] OP_REMOVE = 3'd5;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_NO_CUR = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] value;
	} css_req_t;

	typedef struct packed {
		logic [6:0]  count;
		logic        has_current;
		logic [6:0]  cursor_pos;
		logic [31:0] current_value;
		logic [1:0]  status;
	} css_rsp_t;

endpackage
`default_nettype wire

// File: sv/css_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module css_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: sv/css_ctrl.sv
// Sequencer that decodes operations, shifts entries through the RAM and builds results.
`timescale 1ns / 1ps
`default_nettype none
module css_ctrl #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire css_pkg::css_req_t           req,
	output logic                             rd_en,
	output logic [$clog2(CAPACITY)-1:0]      rd_addr,
	output logic                             wr_en,
	output logic [$clog2(CAPACITY)-1:0]      wr_addr,
	output logic [VALUE_WIDTH-1:0]           wr_data,
	input  wire logic [VALUE_WIDTH-1:0]      rd_data,
	input  wire logic                        res_free,
	output logic                             res_load,
	output css_pkg::css_rsp_t                res
);
	import css_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_UP    = 7'b0000010,
		S_DOWN  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_PLACE = 7'b0010000,
		S_RDREQ = 7'b0100000,
		S_RDWAIT = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          cursor_q;
	logic                   wr_pend_s1;
	logic [AW-1:0]          wr_addr_s1;
	logic [AW-1:0]          src_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [1:0]             status_q;
	logic                   is_rm_q;

	logic                   cur;
	logic                   full;
	logic                   accept;
	logic [CW-1:0]          cursor_inc;
	logic [CW-1:0]          count_dec;
	logic [CW-1:0]          pos;
	logic [CW-1:0]          src_ext;
	logic [63:0]            req_v64;
	logic [63:0]            rd_v64;
	logic [31:0]            count32;
	logic [31:0]            cursor32;

	assign cur        = cursor_q < count_q;
	assign full       = count_q == CAP_C;
	assign req_stall  = state_q != S_IDLE;
	assign accept     = req_valid && (state_q == S_IDLE);
	assign cursor_inc = cursor_q + 1'b1;
	assign count_dec  = count_q - 1'b1;
	assign src_ext    = CW'(src_q);
	assign req_v64    = 64'(req.value);
	assign rd_v64     = 64'(rd_data);
	assign count32    = 32'(count_q);
	assign cursor32   = 32'(cursor_q);

	always_comb begin
		if (req.op == OP_ATTACH) begin
			pos = cur ? cursor_inc : count_q;
		end else begin
			pos = cur ? cursor_q : '0;
		end
	end

	assign rd_en   = (state_q == S_UP) || (state_q == S_DOWN) || ((state_q == S_RDREQ) && cur);
	assign rd_addr = (state_q == S_RDREQ) ? cursor_q[AW-1:0] : src_q;
	assign wr_en   = wr_pend_s1 || (state_q == S_PLACE);
	assign wr_addr = (state_q == S_PLACE) ? cursor_q[AW-1:0] : wr_addr_s1;
	assign wr_data = (state_q == S_PLACE) ? value_q : rd_data;

	assign res_load          = (state_q == S_RDWAIT) && res_free;
	assign res.count         = count32[6:0];
	assign res.has_current   = cur;
	assign res.cursor_pos    = cursor32[6:0];
	assign res.current_value = cur ? rd_v64[31:0] : 32'd0;
	assign res.status        = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			cursor_q   <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == S_UP) || (state_q == S_DOWN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RDREQ;
						case (req.op)
							OP_START: begin
								cursor_q <= '0;
							end
							OP_ADV: begin
								if (cur) begin
									cursor_q <= cursor_inc;
								end
							end
							OP_INSERT, OP_ATTACH: begin
								if (!full) begin
									cursor_q <= pos;
									state_q  <= (count_q > pos) ? S_UP : S_PLACE;
								end
							end
							OP_REMOVE: begin
								if (cur) begin
									if (cursor_inc < count_q) begin
										state_q <= S_DOWN;
									end else begin
										count_q <= count_dec;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_UP: begin
					if (src_ext == cursor_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DOWN: begin
					if (src_ext == count_dec) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (is_rm_q) begin
						count_q <= count_dec;
						state_q <= S_RDREQ;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_RDREQ;
				end
				S_RDREQ: begin
					state_q <= S_RDWAIT;
				end
				S_RDWAIT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UP) begin
			src_q      <= src_q - 1'b1;
			wr_addr_s1 <= src_q + 1'b1;
		end else if (state_q == S_DOWN) begin
			src_q      <= src_q + 1'b1;
			wr_addr_s1 <= src_q - 1'b1;
		end
		if (accept) begin
			value_q  <= req_v64[VALUE_WIDTH-1:0];
			is_rm_q  <= req.op == OP_REMOVE;
			status_q <= ST_DONE;
			case (req.op)
				OP_ADV: begin
					if (!cur) begin
						status_q <= ST_NO_CUR;
					end
				end
				OP_INSERT, OP_ATTACH: begin
					if (full) begin
						status_q <= ST_FULL;
					end
					src_q <= count_dec[AW-1:0];
				end
				OP_REMOVE: begin
					if (!cur) begin
						status_q <= ST_NO_CUR;
					end
					src_q <= cursor_inc[AW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

`include "cursor_sequence_store_assert.svh"

	`CSS_ASSERT_NOW(a_cursor_in_range, 1'b1, cursor_q <= count_q)
	`CSS_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CAP_C)
	`CSS_ASSERT_NOW(a_no_write_idle, state_q == S_IDLE || state_q == S_RDWAIT, !wr_en)
	`CSS_ASSERT_NOW(a_no_rw_collision, rd_en && wr_en, rd_addr != wr_addr)
	`CSS_ASSERT_NEXT(a_place_grows, state_q == S_PLACE, count_q == CW'($past(count_q) + 1'b1))

endmodule
`default_nettype wire

// File: sv/cursor_sequence_store.sv
// Top level of the cursor sequence store: sequencer, item RAM and result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   request  | req_valid, req_stall | req.op, req.value
//   response | rsp_valid, rsp_stall | rsp.count, has_current, cursor_pos, ...
//
// Query, start, advance and rejected transactions update at most the cursor, then read the result.
// Insert and attach first shift the entries from the cursor on up, then place the new value;
// remove shifts the entries behind the cursor down. The RAM moves one entry per cycle through its single write port.
// Reset empties the store at once; the item RAM is not cleared and needs no sweep.
// The next request is taken once the result sits in the output register, even while stalled.
`timescale 1ns / 1ps
`default_nettype none
module cursor_sequence_store #(
	parameter int CAPACITY    = css_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = css_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire css_pkg::css_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output css_pkg::css_rsp_t      rsp
);
	import css_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   res_free;
	logic                   res_load;
	css_rsp_t               res;
	css_rsp_t               rsp_q;
	logic                   rsp_valid_q;

	css_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	css_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (rd_data),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	assign res_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

endmodule
`default_nettype wire

// File: sim/cursor_sequence_store_test.sv
// Self-checking testbench for the cursor sequence store with a list predictor and random stalls.
`timescale 1ns / 1ps
module cursor_sequence_store_test;
	import css_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef enum int {MIX_GROW, MIX_MIXED, MIX_SHRINK} op_mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	css_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	css_rsp_t rsp;

	css_req_t pending_ops[$];
	css_rsp_t expected_rsp[$];
	logic [31:0] list_items[0:CAPACITY-1];
	int list_count = 0;
	int list_cursor = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	logic req_done = 1'b0;

	cursor_sequence_store i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	function automatic css_rsp_t apply_list_op(input css_req_t r);
		css_rsp_t o;
		logic [1:0] st;
		logic on_item;
		int i;
		st = ST_DONE;
		on_item = list_cursor < list_count;
		case (r.op)
			OP_START: list_cursor = 0;
			OP_ADV: begin
				if (on_item) list_cursor++;
				else st = ST_NO_CUR;
			end
			OP_INSERT, OP_ATTACH: begin
				if (list_count >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					if (r.op == OP_INSERT) begin
						if (!on_item) list_cursor = 0;
					end else if (on_item) begin
						list_cursor++;
					end else begin
						list_cursor = list_count;
					end
					for (i = list_count; i > list_cursor; i--) list_items[i] = list_items[i-1];
					list_items[list_cursor] = r.value;
					list_count++;
				end
			end
			OP_REMOVE: begin
				if (on_item) begin
					for (i = list_cursor; i + 1 < list_count; i++) list_items[i] = list_items[i+1];
					list_count--;
				end else begin
					st = ST_NO_CUR;
				end
			end
			default: ;
		endcase
		on_item = list_cursor < list_count;
		o.count = 7'(list_count);
		o.has_current = on_item;
		o.cursor_pos = 7'(list_cursor);
		o.current_value = on_item ? list_items[list_cursor] : 32'd0;
		o.status = st;
		return o;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	task automatic check_rsp(input css_rsp_t got);
		css_rsp_t want;
		if (expected_rsp.size() == 0) begin
			flag_mismatch("unexpected transaction, count", 32'(got.count), 32'd0);
		end else begin
			want = expected_rsp.pop_front();
			if (got.count !== want.count)
				flag_mismatch("count", 32'(got.count), 32'(want.count));
			if (got.has_current !== want.has_current)
				flag_mismatch("has_current", 32'(got.has_current), 32'(want.has_current));
			if (got.cursor_pos !== want.cursor_pos)
				flag_mismatch("cursor_pos", 32'(got.cursor_pos), 32'(want.cursor_pos));
			if (got.current_value !== want.current_value)
				flag_mismatch("current_value", got.current_value, want.current_value);
			if (got.status !== want.status)
				flag_mismatch("status", 32'(got.status), 32'(want.status));
		end
	endtask

	task automatic add_op(input logic [2:0] op, input logic [31:0] value);
		css_req_t r;
		r.op = op;
		r.value = value;
		pending_ops.push_back(r);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_op(input op_mix_t mix);
		int r;
		r = $urandom_range(99);
		case (mix)
			MIX_GROW: begin
				if (r < 45) return OP_INSERT;
				if (r < 90) return OP_ATTACH;
				if (r < 94) return OP_ADV;
				if (r < 97) return OP_START;
				return OP_QUERY;
			end
			MIX_SHRINK: begin
				if (r < 72) return OP_REMOVE;
				if (r < 84) return OP_START;
				if (r < 94) return OP_ADV;
				if (r < 97) return OP_INSERT;
				return OP_QUERY;
			end
			default: begin
				if (r < 20) return OP_INSERT;
				if (r < 40) return OP_ATTACH;
				if (r < 60) return OP_REMOVE;
				if (r < 78) return OP_ADV;
				if (r < 88) return OP_START;
				if (r < 94) return OP_QUERY;
				if (r < 97) return OP_SPARE_LO;
				return OP_SPARE_HI;
			end
		endcase
	endfunction

	task automatic add_episode(input op_mix_t mix, input int n);
		repeat (n) add_op(pick_op(mix), pick_value());
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		add_episode(MIX_GROW, 80);
		add_episode(MIX_MIXED, 30);
		add_episode(MIX_SHRINK, 60);
		while (pending_ops.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_stall <= 1'b0;
		end else begin
			if (!req_valid || req_done) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_ops.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_done <= 1'b0;
		end else begin
			req_done <= req_valid && !req_stall;
			if (req_valid && !req_stall)
				expected_rsp.push_back(apply_list_op(req));
			if (rsp_valid && !rsp_stall)
				check_rsp(rsp);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (req_valid || pending_ops.size() != 0 || expected_rsp.size() != 0) begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles + 1 >= QUIET_LIMIT) begin
					$display("%0t ns: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
					$display("cursor_sequence_store_test NOT OK");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_op(OP_QUERY, 32'h1234_5678);
		add_op(OP_START, 32'd0);
		add_op(OP_ADV, 32'd0);
		add_op(OP_REMOVE, 32'd0);
		add_op(OP_INSERT, 32'd0);
		add_op(OP_ATTACH, 32'hFFFF_FFFF);
		add_op(OP_START, 32'd0);
		add_op(OP_ADV, 32'd0);
		add_op(OP_ADV, 32'd0);
		add_op(OP_ATTACH, 32'h8000_0001);
		add_op(OP_ADV, 32'd0);
		add_op(OP_INSERT, 32'h7FFF_FFFE);
		add_op(OP_SPARE_LO, 32'hFFFF_FFFF);
		add_op(OP_SPARE_HI, 32'h5555_5555);
		add_op(OP_ADV, 32'd0);
		add_op(OP_INSERT, 32'hA5A5_A5A5);
		add_op(OP_ATTACH, 32'h5A5A_5A5A);
		add_op(OP_REMOVE, 32'd0);
		add_op(OP_ADV, 32'd0);
		add_op(OP_ADV, 32'd0);
		add_op(OP_REMOVE, 32'd0);
		add_op(OP_START, 32'd0);
		add_op(OP_REMOVE, 32'd0);
		add_op(OP_QUERY, 32'd0);

		run_phase(31, 76);
		run_phase(76, 31);
		run_phase(0, 0);

		repeat (80) @(posedge clk);
		if (fail_count == 0) begin
			$display("cursor_sequence_store_test OK");
		end else begin
			$display("cursor_sequence_store_test NOT OK");
		end
		$finish;
	end
endmodule
